FILE: sv/tps_pkg.sv
// shared types, constants and control program for the timer prescaler search
package tps_pkg;

  localparam int REQ_W = 22;
  localparam int RATE_W = 20;
  localparam int SEL_W = 3;
  localparam int CNT_W = 8;
  localparam int ERR_W = 24;
  localparam int BIT_IDX_W = $clog2(RATE_W);

  localparam int unsigned CLOCK_HZ = 2457600;
  localparam logic [ERR_W-1:0] START_ERROR = 24'hFFFFFF;
  localparam logic [CNT_W-1:0] COUNT_LAST = CNT_W'(256 - 1);
  localparam logic [CNT_W-1:0] COUNT_FIRST = CNT_W'(1);
  localparam logic [SEL_W-1:0] SEL_FIRST = SEL_W'(7);
  localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(1);

  // prescaled clock per select, entry 0 unused
  localparam logic [RATE_W-1:0] PRESCALE_BASE [8] = '{
    RATE_W'(CLOCK_HZ / 1),  RATE_W'(CLOCK_HZ / 4),  RATE_W'(CLOCK_HZ / 10),
    RATE_W'(CLOCK_HZ / 16), RATE_W'(CLOCK_HZ / 50), RATE_W'(CLOCK_HZ / 64),
    RATE_W'(CLOCK_HZ / 100), RATE_W'(CLOCK_HZ / 200)
  };

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE     = 3'd0;
  localparam step_t STEP_SEL      = 3'd1;
  localparam step_t STEP_DIV_LOAD = 3'd2;
  localparam step_t STEP_DIV_RUN  = 3'd3;
  localparam step_t STEP_COMPARE  = 3'd4;
  localparam step_t STEP_NEXT_SEL = 3'd5;
  localparam step_t STEP_EMIT     = 3'd6;
  localparam step_t STEP_SPARE    = 3'd7;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_DIV_LAST,
    COND_SCAN_END,
    COND_SEL_LAST,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic take_in;
    logic init_cnt;
    logic div_start;
    logic div_step;
    logic compare;
    logic inc_cnt;
    logic dec_sel;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic div_last;
    logic scan_end;
    logic sel_last;
    logic out_free;
  } status_t;

  typedef struct packed {
    cond_t cond;
    step_t jmp_t;
    step_t jmp_f;
    ctrl_t ctrl;
  } uword_t;

  localparam ctrl_t NO_OP = '0;

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{cond: COND_ALWAYS, jmp_t: STEP_IDLE, jmp_f: STEP_IDLE, ctrl: NO_OP};
    unique case (s)
      STEP_IDLE: begin
        w.cond = COND_IN_VALID; w.jmp_t = STEP_SEL; w.jmp_f = STEP_IDLE;
        w.ctrl.take_in = 1'b1;
      end
      STEP_SEL: begin
        w.jmp_t = STEP_DIV_LOAD; w.jmp_f = STEP_DIV_LOAD;
        w.ctrl.init_cnt = 1'b1;
      end
      STEP_DIV_LOAD: begin
        w.jmp_t = STEP_DIV_RUN; w.jmp_f = STEP_DIV_RUN;
        w.ctrl.div_start = 1'b1;
      end
      STEP_DIV_RUN: begin
        w.cond = COND_DIV_LAST; w.jmp_t = STEP_COMPARE; w.jmp_f = STEP_DIV_RUN;
        w.ctrl.div_step = 1'b1;
      end
      STEP_COMPARE: begin
        w.cond = COND_SCAN_END; w.jmp_t = STEP_NEXT_SEL; w.jmp_f = STEP_DIV_LOAD;
        w.ctrl.compare = 1'b1; w.ctrl.inc_cnt = 1'b1;
      end
      STEP_NEXT_SEL: begin
        w.cond = COND_SEL_LAST; w.jmp_t = STEP_EMIT; w.jmp_f = STEP_SEL;
        w.ctrl.dec_sel = 1'b1;
      end
      STEP_EMIT: begin
        w.cond = COND_OUT_FREE; w.jmp_t = STEP_IDLE; w.jmp_f = STEP_EMIT;
        w.ctrl.emit = 1'b1;
      end
      STEP_SPARE: begin
        w.jmp_t = STEP_IDLE; w.jmp_f = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: sv/tps_req_if.sv
// request channel carrying the wanted rate
interface tps_req_if import tps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] wanted_rate;

  modport source (output valid, wanted_rate, input ready);
  modport sink (input valid, wanted_rate, output ready);
endinterface

FILE: sv/tps_res_if.sv
// result channel carrying the chosen timer setting
interface tps_res_if import tps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SEL_W-1:0]  prescale_select;
  logic [CNT_W-1:0]  count_divisor;
  logic [RATE_W-1:0] achieved_rate;

  modport source (output valid, prescale_select, count_divisor, achieved_rate, input ready);
  modport sink (input valid, prescale_select, count_divisor, achieved_rate, output ready);
endinterface

FILE: sv/tps_useq.sv
// microcode sequencer: step counter, control store and conditional jumps
module tps_useq import tps_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl
);

  step_t  step;
  step_t  step_next;
  uword_t word;
  logic   cond_true;

  always_comb begin
    word = ucode(step);
    unique case (word.cond)
      COND_ALWAYS:   cond_true = 1'b1;
      COND_IN_VALID: cond_true = status.in_valid;
      COND_DIV_LAST: cond_true = status.div_last;
      COND_SCAN_END: cond_true = status.scan_end;
      COND_SEL_LAST: cond_true = status.sel_last;
      COND_OUT_FREE: cond_true = status.out_free;
      default:       cond_true = 1'b1;
    endcase
    step_next = cond_true ? word.jmp_t : word.jmp_f;
    ctrl = word.ctrl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

FILE: sv/tps_divider.sv
// restoring serial divider, one quotient bit per cycle while advance is high
module tps_divider import tps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              advance,
  input  logic [RATE_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic [RATE_W-1:0] quotient,
  output logic              last
);

  logic [BIT_IDX_W-1:0] bit_idx;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W:0]       rem_sh;
  logic [CNT_W:0]       diff;
  logic                 fits;

  assign rem_sh = {rem, quotient[RATE_W-1]};
  assign diff = rem_sh - {1'b0, divisor};
  assign fits = rem_sh >= {1'b0, divisor};
  assign last = bit_idx == BIT_IDX_W'(RATE_W - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_idx <= '0;
    end else if (start) begin
      bit_idx <= '0;
    end else if (advance) begin
      bit_idx <= bit_idx + BIT_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quotient <= dividend;
    end else if (advance) begin
      rem <= fits ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quotient <= {quotient[RATE_W-2:0], fits};
    end
  end

endmodule

FILE: sv/tps_datapath.sv
// search datapath: candidate setting, error compare, best setting and result register
module tps_datapath import tps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_t             ctrl,
  input  logic              in_valid,
  input  logic [REQ_W-1:0]  wanted_rate,
  input  logic              out_ready,
  output status_t           status,
  output logic              out_valid,
  output logic [SEL_W-1:0]  prescale_select,
  output logic [CNT_W-1:0]  count_divisor,
  output logic [RATE_W-1:0] achieved_rate
);

  logic [REQ_W-1:0]  want;
  logic [SEL_W-1:0]  sel;
  logic [CNT_W-1:0]  cnt;
  logic [ERR_W-1:0]  best_err;
  logic [RATE_W-1:0] best_rate;
  logic [SEL_W-1:0]  best_sel;
  logic [CNT_W-1:0]  best_cnt;
  logic [RATE_W-1:0] rate;
  logic [REQ_W-1:0]  rate_ext;
  logic [REQ_W-1:0]  err;
  logic              better;
  logic              div_last;
  logic              take;
  logic              emit;

  tps_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .advance  (ctrl.div_step),
    .dividend (PRESCALE_BASE[sel]),
    .divisor  (cnt),
    .quotient (rate),
    .last     (div_last)
  );

  assign rate_ext = {{(REQ_W - RATE_W){1'b0}}, rate};
  assign err = (want > rate_ext) ? want - rate_ext : rate_ext - want;
  assign better = {{(ERR_W - REQ_W){1'b0}}, err} < best_err;
  assign take = ctrl.take_in && in_valid;
  assign emit = ctrl.emit && (!out_valid || out_ready);

  assign status.in_valid = in_valid;
  assign status.div_last = div_last;
  assign status.scan_end = (rate_ext < want) || (cnt == COUNT_LAST);
  assign status.sel_last = sel == SEL_LAST;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (take) begin
      want <= wanted_rate;
      sel <= SEL_FIRST;
      best_err <= START_ERROR;
      best_rate <= '0;
      best_sel <= SEL_LAST;
      best_cnt <= COUNT_FIRST;
    end
    if (ctrl.init_cnt) begin
      cnt <= COUNT_FIRST;
    end
    if (ctrl.inc_cnt) begin
      cnt <= cnt + CNT_W'(1);
    end
    if (ctrl.dec_sel) begin
      sel <= sel - SEL_W'(1);
    end
    if (ctrl.compare && better) begin
      best_err <= {{(ERR_W - REQ_W){1'b0}}, err};
      best_rate <= rate;
      best_sel <= sel;
      best_cnt <= cnt;
    end
    if (emit) begin
      prescale_select <= best_sel;
      count_divisor <= best_cnt;
      achieved_rate <= best_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_candidate_legal: assert property (@(posedge clk) disable iff (rst)
    ctrl.compare |-> sel != '0 && cnt != '0)
    else $error("candidate with zero select or divisor");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("result register not loaded after emit");

  a_take_inits_best: assert property (@(posedge clk) disable iff (rst)
    take |=> best_err == START_ERROR && sel == SEL_FIRST)
    else $error("search state not initialized on new request");

  a_compare_after_div: assert property (@(posedge clk) disable iff (rst)
    ctrl.compare |-> $past(ctrl.div_step) && $past(div_last))
    else $error("compare without a finished division");
`endif

endmodule

FILE: sv/timer_prescaler_search.sv
// top level of the timer prescaler search
// Finds the timer prescaler select and count divisor whose rate comes nearest a wanted
// rate. Each request returns one result. One candidate takes a load step, a serial divider
// step per quotient bit and a compare step; a request scans up to 1785 candidates. A
// finished result waits in the output register while the next request is taken.
module timer_prescaler_search import tps_pkg::*; (
  input logic   clk,
  input logic   rst,
  tps_req_if.sink   req,
  tps_res_if.source res
);

  ctrl_t   ctrl;
  status_t status;

  assign req.ready = ctrl.take_in;

  tps_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  tps_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .in_valid        (req.valid),
    .wanted_rate     (req.wanted_rate),
    .out_ready       (res.ready),
    .status          (status),
    .out_valid       (res.valid),
    .prescale_select (res.prescale_select),
    .count_divisor   (res.count_divisor),
    .achieved_rate   (res.achieved_rate)
  );

endmodule

FILE: test/timer_prescaler_search_tb.sv
// testbench: nearest-rate timer setting search checked against an in-bench search
module timer_prescaler_search_tb;
  import tps_pkg::*;

  localparam int unsigned BASE_CLOCK_HZ = 2457600;
  localparam int unsigned PRESCALER_DIV [8] = '{1, 4, 10, 16, 50, 64, 100, 200};
  localparam int unsigned NO_ERROR_YET = 32'hFFFFFF;
  localparam int unsigned LIMIT_CYCLES = 20_000_000;
  localparam int unsigned HOLD_CYCLES = 4000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int RANDOM_N = 78;
  localparam int FAST_N = 8;
  localparam int DIRECTED_N = 22;
  localparam logic [REQ_W-1:0] DIRECTED [DIRECTED_N] = '{
    22'd0, 22'd1, 22'd47, 22'd48, 22'd49, 22'd50, 22'd100, 22'd1000,
    22'd12287, 22'd12288, 22'd24000, 22'd30000, 22'd150000, 22'd245760,
    22'd307200, 22'd460800, 22'd614399, 22'd614400, 22'd614401,
    22'h3FFFFF, 22'h2AAAAA, 22'h155555
  };

  typedef struct packed {
    logic [SEL_W-1:0]  prescale_select;
    logic [CNT_W-1:0]  count_divisor;
    logic [RATE_W-1:0] achieved_rate;
  } timer_setting_t;

  class setting_scoreboard;
    timer_setting_t pending[$];
    int unsigned errors;

    function timer_setting_t nearest_setting(logic [REQ_W-1:0] want);
      int unsigned want_hz, base, rate, err, best_err;
      timer_setting_t best;
      want_hz = want;
      best_err = NO_ERROR_YET;
      best.prescale_select = SEL_W'(1);
      best.count_divisor = CNT_W'(1);
      best.achieved_rate = '0;
      for (int sel = 7; sel >= 1; sel--) begin
        base = BASE_CLOCK_HZ / PRESCALER_DIV[sel];
        for (int cnt = 1; cnt < 256; cnt++) begin
          rate = base / cnt;
          err = (want_hz > rate) ? want_hz - rate : rate - want_hz;
          if (err < best_err) begin
            best_err = err;
            best.prescale_select = SEL_W'(sel);
            best.count_divisor = CNT_W'(cnt);
            best.achieved_rate = RATE_W'(rate);
          end
          if (rate < want_hz) break;
        end
      end
      return best;
    endfunction

    function void note_request(logic [REQ_W-1:0] want);
      pending.push_back(nearest_setting(want));
    endfunction

    function void flag(string what, timer_setting_t want_s, timer_setting_t got);
      errors++;
      if (errors <= 10)
        $display({"mismatch (%s): expected sel %0d cnt %0d rate %0d, ",
                  "got sel %0d cnt %0d rate %0d"},
                 what, want_s.prescale_select, want_s.count_divisor, want_s.achieved_rate,
                 got.prescale_select, got.count_divisor, got.achieved_rate);
    endfunction

    function void check_result(timer_setting_t got);
      timer_setting_t want_s;
      if (pending.size() == 0) begin
        flag("unexpected result", '0, got);
        return;
      end
      want_s = pending.pop_front();
      if (got.prescale_select !== want_s.prescale_select ||
          got.count_divisor !== want_s.count_divisor ||
          got.achieved_rate !== want_s.achieved_rate)
        flag("wrong setting", want_s, got);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int unsigned cycle_count = 0;
  int unsigned results_seen = 0;
  setting_scoreboard board;

  tps_req_if req_ch ();
  tps_res_if res_ch ();

  timer_prescaler_search i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timer_prescaler_search verification failed");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic [REQ_W-1:0] random_request(bit fast);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (fast) return REQ_W'($urandom_range(200000, 4194303));
    if (pick < 5) return REQ_W'($urandom_range(0, 3000));
    if (pick < 30) return REQ_W'($urandom_range(3000, 50000));
    if (pick < 75) return REQ_W'($urandom_range(50000, 614400));
    return REQ_W'($urandom());
  endfunction

  task automatic send_request(logic [REQ_W-1:0] want);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.wanted_rate <= want;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    board.note_request(want);
  endtask

  // result side, with one long hold-off right after the directed transactions
  initial begin
    int unsigned idle;
    timer_setting_t got;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      idle = draw_gap();
      if (results_seen == DIRECTED_N) idle = HOLD_CYCLES;
      if (idle > 0) begin
        res_ch.ready <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      got.prescale_select = res_ch.prescale_select;
      got.count_divisor = res_ch.count_divisor;
      got.achieved_rate = res_ch.achieved_rate;
      board.check_result(got);
      results_seen++;
    end
  end

  initial begin
    int unsigned failures;
    board = new();
    req_ch.valid <= 1'b0;
    req_ch.wanted_rate <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (DIRECTED[i]) send_request(DIRECTED[i]);
    req_ch.valid <= 1'b0;
    // sender pause until the directed transactions are all answered
    while (board.pending.size() != 0) @(posedge clk);
    for (int i = 0; i < RANDOM_N; i++) send_request(random_request(i < FAST_N));
    req_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    failures = board.errors + board.pending.size();
    if (failures == 0) begin
      $display("timer_prescaler_search verification clean");
    end else begin
      $display("timer_prescaler_search verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/tps_pkg.sv
sv/tps_req_if.sv
sv/tps_res_if.sv
sv/tps_useq.sv
sv/tps_divider.sv
sv/tps_datapath.sv
sv/timer_prescaler_search.sv
test/timer_prescaler_search_tb.sv
